### hw/rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier: item layouts,
// configuration register codes, reset values and event kinds.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // default sizing
    localparam int NUM_BUTTONS_DEF = 8;
    localparam int TIME_BITS_DEF   = 48;

    // field widths
    localparam int IN_TIME_W  = 48;
    localparam int BTN_W      = 3;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DEB_W      = 20;
    localparam int LPT_W      = 24;
    localparam int RP_W       = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd2;

    // configuration reset values (microseconds)
    localparam logic [DEB_W-1:0] DEB_RESET = 20'd5000;
    localparam logic [LPT_W-1:0] LPT_RESET = 24'd2000000;
    localparam logic [RP_W-1:0]  RP_RESET  = 24'd100000;

    // operations
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_SHORT        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LONG_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG_START   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REPEAT       = 2'd3;

    typedef struct packed {
        logic                 operation;
        logic [BTN_W-1:0]     button_index;
        logic                 level;
        logic [IN_TIME_W-1:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic [BTN_W-1:0]  button_id;
        logic [KIND_W-1:0] event_kind;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_time;
        logic [LPT_W-1:0] long_press_time;
        logic [RP_W-1:0]  repeat_period;
    } t_cfg;

    // item controls seen by the classifier stages
    typedef struct packed {
        logic advance;
        logic op;
        logic level;
    } t_item_ctl;

    // classifier verdict for one button
    typedef struct packed {
        logic              ev;
        logic [KIND_W-1:0] kind;
    } t_decision;

endpackage

### hw/rtl/bpc_state_mem.sv
// ----------------------------------------------------------------------------
// bpc_state_mem
// Per-button state store: one write port, one read port, registered read
// data. Valid flags make never-written entries read as all zero.
// ----------------------------------------------------------------------------
module bpc_state_mem #(
    parameter int NUM_BUTTONS = 8,
    parameter int ENTRY_W     = 146,
    localparam int IDX_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [IDX_W-1:0]   i_rd_addr,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  logic [ENTRY_W-1:0] i_wr_data,
    output logic [ENTRY_W-1:0] o_rd_data
);

    logic [ENTRY_W-1:0]     r_mem [NUM_BUTTONS];
    logic [ENTRY_W-1:0]     r_rd_data;
    logic [NUM_BUTTONS-1:0] r_vld;
    logic                   r_rd_vld;

    // storage array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // written flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### hw/rtl/bpc_classify.sv
// ----------------------------------------------------------------------------
// bpc_classify
// Two-stage datapath for one button: stage 1 takes the wrapped time
// differences from the entry just read, stage 2 compares them against the
// thresholds and builds the updated entry and the event.
// ----------------------------------------------------------------------------
module bpc_classify #(
    parameter int TIME_BITS = 48,
    localparam int ENTRY_W  = 3 * TIME_BITS + 2
) (
    input  logic                 i_clk,
    input  bpc_pkg::t_item_ctl   i_ctl,
    input  logic [TIME_BITS-1:0] i_now,
    input  bpc_pkg::t_cfg        i_cfg,
    input  logic [ENTRY_W-1:0]   i_entry,
    output logic [ENTRY_W-1:0]   o_entry_new,
    output bpc_pkg::t_decision   o_dec
);
    import bpc_pkg::*;

    // entry layout: {last_edge, press, repeat, held, long_on}
    localparam int LON_POS   = 0;
    localparam int HELD_POS  = 1;
    localparam int REP_POS   = 2;
    localparam int PRESS_POS = 2 + TIME_BITS;
    localparam int LAST_POS  = 2 + 2 * TIME_BITS;

    logic [ENTRY_W-1:0]   r_ent;
    logic [TIME_BITS-1:0] r_d_edge;
    logic [TIME_BITS-1:0] r_d_press;
    logic [TIME_BITS-1:0] r_d_rep;

    logic [TIME_BITS-1:0] w_deb;
    logic [TIME_BITS-1:0] w_lpt;
    logic [TIME_BITS-1:0] w_rp;
    logic                 w_held;
    logic                 w_lon;

    logic [TIME_BITS-1:0] n_last;
    logic [TIME_BITS-1:0] n_press;
    logic [TIME_BITS-1:0] n_rep;
    logic                 n_held;
    logic                 n_lon;

    // stage 1: elapsed times, wrapping at the time width
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_ent     <= i_entry;
            r_d_edge  <= i_now - i_entry[LAST_POS +: TIME_BITS];
            r_d_press <= i_now - i_entry[PRESS_POS +: TIME_BITS];
            r_d_rep   <= i_now - i_entry[REP_POS +: TIME_BITS];
        end
    end

    assign w_deb  = TIME_BITS'(i_cfg.debounce_time);
    assign w_lpt  = TIME_BITS'(i_cfg.long_press_time);
    assign w_rp   = TIME_BITS'(i_cfg.repeat_period);
    assign w_held = r_ent[HELD_POS];
    assign w_lon  = r_ent[LON_POS];

    // stage 2: classify and update
    always_comb begin
        n_last     = r_ent[LAST_POS +: TIME_BITS];
        n_press    = r_ent[PRESS_POS +: TIME_BITS];
        n_rep      = r_ent[REP_POS +: TIME_BITS];
        n_held     = w_held;
        n_lon      = w_lon;
        o_dec.ev   = 1'b0;
        o_dec.kind = KIND_SHORT;
        if (i_ctl.op == OP_EDGE) begin
            // edges inside the debounce window leave the entry untouched
            if (r_d_edge >= w_deb) begin
                n_last = i_now;
                if (i_ctl.level) begin
                    if (!w_held) begin
                        n_held  = 1'b1;
                        n_press = i_now;
                        n_lon   = 1'b0;
                        n_rep   = '0;
                    end
                end else if (w_held) begin
                    n_held   = 1'b0;
                    o_dec.ev = 1'b1;
                    if (!w_lon && (r_d_press < w_lpt)) begin
                        o_dec.kind = KIND_SHORT;
                    end else begin
                        o_dec.kind = KIND_LONG_RELEASE;
                    end
                    n_lon = 1'b0;
                    n_rep = '0;
                end
            end
        end else if (w_held) begin
            // tick: long press start, then repeats
            if (!w_lon) begin
                if (r_d_press >= w_lpt) begin
                    n_lon      = 1'b1;
                    n_rep      = i_now;
                    o_dec.ev   = 1'b1;
                    o_dec.kind = KIND_LONG_START;
                end
            end else if (r_d_rep >= w_rp) begin
                n_rep      = i_now;
                o_dec.ev   = 1'b1;
                o_dec.kind = KIND_REPEAT;
            end
        end
    end

    assign o_entry_new = {n_last, n_press, n_rep, n_held, n_lon};

endmodule

### hw/rtl/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounces button edges, classifies releases as short or long, and on tick
// items walks the held buttons to report long-press starts and repeats.
// ----------------------------------------------------------------------------
// An in-range edge reads its entry, passes classifier stages 1 and 2 and the
// pending register. A tick walks every button; the read port steps one button
// per cycle unless the output stalls. An out-of-range edge is dropped. A new
// item is accepted once the previous one has handed its last result
// to the output register. Reset is synchronous: registers return to their
// defaults and per-button state reads as zero through written flags at once.
module button_press_classifier #(
    parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = bpc_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bpc_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bpc_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bpc_pkg::*;

    localparam int IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int ENTRY_W = 3 * TIME_BITS + 2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    t_cfg                 r_cfg;

    // current item
    logic                 r_op;
    logic                 r_lvl;
    logic [TIME_BITS-1:0] r_now;

    // read issue and pipeline tracking
    logic                 r_iss_act;
    logic [IDX_W-1:0]     r_iss_addr;
    logic                 r_s1_valid;
    logic [IDX_W-1:0]     r_s1_idx;
    logic                 r_s1_end;
    logic                 r_s2_valid;
    logic [IDX_W-1:0]     r_s2_idx;
    logic                 r_s2_end;

    // pending result, held back until we know whether it is the last
    logic                 r_pend_v;
    logic [BTN_W-1:0]     r_pend_id;
    logic [KIND_W-1:0]    r_pend_kind;

    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out_item            r_out;

    logic                 w_accept;
    logic                 w_btn_ok;
    logic                 w_start;
    logic                 w_iss_end;
    logic                 w_out_free;
    logic                 w_stall;
    logic                 w_s2_fire;
    logic                 w_push_mid;
    logic                 w_flush_done;
    logic [ENTRY_W-1:0]   w_rd_data;
    logic [ENTRY_W-1:0]   w_wr_data;
    t_item_ctl            w_ctl;
    t_decision            w_dec;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_btn_ok     = (32'(i_in_item.button_index) < NUM_BUTTONS);
    assign w_start      = w_accept && ((i_in_item.operation == OP_TICK) || w_btn_ok);
    assign w_iss_end    = (r_op == OP_EDGE) || (r_iss_addr == LAST_IDX);
    assign w_out_free   = !r_out_valid || i_out_ready;
    // a second event cannot move while the pending one has nowhere to go
    assign w_stall      = r_s2_valid && w_dec.ev && r_pend_v && !w_out_free;
    assign w_s2_fire    = r_s2_valid && !w_stall;
    assign w_push_mid   = w_s2_fire && w_dec.ev && r_pend_v;
    assign w_flush_done = (r_state == ST_FLUSH) && (!r_pend_v || w_out_free);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time   <= DEB_RESET;
            r_cfg.long_press_time <= LPT_RESET;
            r_cfg.repeat_period   <= RP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:   r_cfg.debounce_time   <= i_cfg_data[DEB_W-1:0];
                CFG_LONG_PRESS: r_cfg.long_press_time <= i_cfg_data[LPT_W-1:0];
                CFG_REPEAT:     r_cfg.repeat_period   <= i_cfg_data[RP_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_s2_fire && r_s2_end) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (w_flush_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output register next valid
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_push_mid || (w_flush_done && r_pend_v)) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iss_act   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_start) begin
                r_iss_act <= 1'b1;
            end else if (r_iss_act && !w_stall && w_iss_end) begin
                r_iss_act <= 1'b0;
            end
            if (!w_stall) begin
                r_s1_valid <= r_iss_act;
                r_s2_valid <= r_s1_valid;
            end
            if (w_s2_fire && w_dec.ev) begin
                r_pend_v <= 1'b1;
            end else if (w_flush_done) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // item, address and result payload
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_op  <= i_in_item.operation;
            r_lvl <= i_in_item.level;
            r_now <= TIME_BITS'(i_in_item.time_now);
            if (i_in_item.operation == OP_TICK) begin
                r_iss_addr <= '0;
            end else begin
                r_iss_addr <= IDX_W'(i_in_item.button_index);
            end
        end else if (r_iss_act && !w_stall && !w_iss_end) begin
            r_iss_addr <= r_iss_addr + IDX_W'(1);
        end
        if (!w_stall) begin
            r_s1_idx <= r_iss_addr;
            r_s1_end <= w_iss_end;
            r_s2_idx <= r_s1_idx;
            r_s2_end <= r_s1_end;
        end
        if (w_s2_fire && w_dec.ev) begin
            r_pend_id   <= BTN_W'(r_s2_idx);
            r_pend_kind <= w_dec.kind;
        end
        if (w_push_mid) begin
            r_out.button_id  <= r_pend_id;
            r_out.event_kind <= r_pend_kind;
            r_out.last       <= 1'b0;
        end else if (w_flush_done && r_pend_v) begin
            r_out.button_id  <= r_pend_id;
            r_out.event_kind <= r_pend_kind;
            r_out.last       <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // per-button state; one item at a time, so a read never overtakes a write
    bpc_state_mem #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .ENTRY_W     (ENTRY_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_iss_act && !w_stall),
        .i_rd_addr (r_iss_addr),
        .i_wr_en   (w_s2_fire),
        .i_wr_addr (r_s2_idx),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    assign w_ctl.advance = !w_stall;
    assign w_ctl.op      = r_op;
    assign w_ctl.level   = r_lvl;

    bpc_classify #(
        .TIME_BITS (TIME_BITS)
    ) u_classify (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_now       (r_now),
        .i_cfg       (r_cfg),
        .i_entry     (w_rd_data),
        .o_entry_new (w_wr_data),
        .o_dec       (w_dec)
    );

`ifndef NO_ASSERTIONS
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!r_iss_act && !r_s1_valid && !r_s2_valid))
        else $error("pipeline busy while accepting items");

    a_stall_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |-> (r_state == ST_RUN))
        else $error("stall outside of a scan");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FLUSH) && w_out_free) |=> !r_pend_v)
        else $error("pending result survived the flush");

    a_mid_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_mid |=> (o_out_valid && !o_out_item.last))
        else $error("displaced result marked last");
`endif

endmodule
